/* design/llacr_pkg.sv */
// shared constants, codes, types and the level mapping function of the
// light level average change reporter; no dependencies
package llacr_pkg;

  localparam int WINDOW_DEFAULT = 3;

  localparam logic [7:0] LEVEL_LOW       = 8'd75;
  localparam logic [7:0] LEVEL_FOUR      = 8'd90;
  localparam logic [7:0] LEVEL_BASE      = 8'd100;
  localparam logic [7:0] LEVEL_HIGH      = 8'd225;
  localparam logic [7:0] LEVEL_STEP      = 8'd10;
  localparam logic [7:0] THRESHOLD_RESET = 8'd60;

  localparam logic [1:0] OP_SAMPLE  = 2'd0;
  localparam logic [1:0] OP_ENABLE  = 2'd1;
  localparam logic [1:0] OP_DISABLE = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [7:0] map_level(input logic [15:0] raw);
    logic [7:0] lvl;
    if (raw <= 16'd3) begin
      lvl = LEVEL_LOW;
    end else if (raw == 16'd4) begin
      lvl = LEVEL_FOUR;
    end else if (raw <= 16'd16) begin
      lvl = LEVEL_BASE + 8'(raw[4:0] - 5'd5) * LEVEL_STEP;
    end else begin
      lvl = LEVEL_HIGH;
    end
    return lvl;
  endfunction

endpackage

/* design/llacr_div.sv */
// restoring divider, one quotient bit per cycle
// depends on llacr_pkg for the status struct
module llacr_div #(
  parameter int DIVIDEND_W = 10,
  parameter int DIVISOR_W  = 2
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [DIVIDEND_W-1:0]  dividend,
  input  logic [DIVISOR_W-1:0]   divisor,
  output llacr_pkg::div_stat_t   stat,
  output logic [DIVIDEND_W-1:0]  quotient
);
  import llacr_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [CNT_W-1:0]      cnt_r;
  logic                  done_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVISOR_W-1:0]  div_r;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;

  assign trial = {rem_r, quo_r[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, div_r};
  assign ge    = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNT_W'(DIVIDEND_W);
        rem_r <= '0;
        div_r <= divisor;
        quo_r <= dividend;
      end else if (cnt_r != '0) begin
        rem_r <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        quo_r <= {quo_r[DIVIDEND_W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = cnt_r != '0;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

/* design/light_level_average_change_reporter.sv */
// a sample's result passes through the summing adder, one filled window entry
// (1 to WINDOW entries) per cycle, and then through the bit-serial divider.
// one input transaction at a time; ready again once results are handed to the
// output register or none is due; when both reports are due, the second one
// follows the first. enable/disable transactions only set or clear the force
// flag and leave the block ready.
// reset: window empty, last reported level 0, force flag clear, threshold 60
module light_level_average_change_reporter #(
  parameter int WINDOW = llacr_pkg::WINDOW_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [1:0] operation, [17:2] sample, [23:18] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] reported_level, [15:8] window_mean
  output logic        out_tlast,  // last_of_run
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data    // change_threshold
);
  import llacr_pkg::*;

  localparam int SUM_W = $clog2(WINDOW * 225 + 1);
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV_GO,
    ST_DIV,
    ST_SEND
  } state_t;

  state_t            state_r;
  logic [7:0]        win_r [WINDOW];
  logic [IDX_W-1:0]  slot_r;
  logic [CNT_W-1:0]  fill_r;
  logic [IDX_W-1:0]  idx_r;
  logic [SUM_W-1:0]  sum_r;
  logic [7:0]        level_r;
  logic [7:0]        mean_r;
  logic [7:0]        last_rep_r;
  logic [7:0]        thresh_r;
  logic              force_r;
  logic              send_change_r;
  logic              div_start_r;
  logic              out_valid_r;
  logic [15:0]       out_data_r;
  logic              out_last_r;

  logic [1:0]        op;
  logic [15:0]       raw;
  logic [7:0]        level_nxt;
  logic [7:0]        mean_nxt;
  logic [7:0]        diff;
  logic              out_free;
  logic              send_now;
  div_stat_t         div_stat;
  logic [SUM_W-1:0]  quotient;

  assign op        = in_tdata[1:0];
  assign raw       = in_tdata[17:2];
  assign level_nxt = map_level(raw);
  assign mean_nxt  = quotient[7:0];
  assign diff      = (mean_nxt >= last_rep_r) ? mean_nxt - last_rep_r : last_rep_r - mean_nxt;
  assign out_free  = !out_valid_r || out_tready;
  // a report goes into the output register this cycle
  assign send_now  = (state_r == ST_SEND) && (send_change_r || force_r) && out_free;

  llacr_div #(
    .DIVIDEND_W(SUM_W),
    .DIVISOR_W (CNT_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start_r),
    .dividend(sum_r),
    .divisor (fill_r),
    .stat    (div_stat),
    .quotient(quotient)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      slot_r        <= '0;
      fill_r        <= '0;
      last_rep_r    <= '0;
      thresh_r      <= THRESHOLD_RESET;
      force_r       <= 1'b0;
      send_change_r <= 1'b0;
      div_start_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      if (send_now) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        thresh_r <= cfg_data;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            case (op)
              OP_SAMPLE: begin
                level_r       <= level_nxt;
                win_r[slot_r] <= level_nxt;
                slot_r        <= (slot_r == IDX_W'(WINDOW - 1)) ? '0 : slot_r + 1'b1;
                if (fill_r != CNT_W'(WINDOW)) begin
                  fill_r <= fill_r + 1'b1;
                end
                sum_r   <= '0;
                idx_r   <= '0;
                state_r <= ST_SUM;
              end
              OP_ENABLE:  force_r <= 1'b1;
              OP_DISABLE: force_r <= 1'b0;
              default: ;
            endcase
          end
        end
        ST_SUM: begin
          // one window entry per cycle through the shared adder
          sum_r <= sum_r + SUM_W'(win_r[idx_r]);
          idx_r <= idx_r + 1'b1;
          if (CNT_W'(idx_r) + 1'b1 == fill_r) begin
            state_r <= ST_DIV_GO;
          end
        end
        ST_DIV_GO: begin
          div_start_r <= 1'b1;
          state_r     <= ST_DIV;
        end
        ST_DIV: begin
          if (div_stat.done) begin
            mean_r        <= mean_nxt;
            send_change_r <= diff >= thresh_r;
            state_r       <= ST_SEND;
          end
        end
        ST_SEND: begin
          if (!send_change_r && !force_r) begin
            state_r <= ST_IDLE;
          end else if (out_free) begin
            out_data_r  <= {mean_r, level_r};
            last_rep_r  <= level_r;
            if (send_change_r) begin
              send_change_r <= 1'b0;
              out_last_r    <= !force_r;
              if (!force_r) begin
                state_r <= ST_IDLE;
              end
            end else begin
              force_r    <= 1'b0;
              out_last_r <= 1'b1;
              state_r    <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE) && !div_stat.busy;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  // threshold writes only between transactions
  assign cfg_ready  = (state_r == ST_IDLE);

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// self-checking testbench for light_level_average_change_reporter: random and
// directed samples and enable/disable events, checked against a level predictor
// depends on design/llacr_pkg.sv and design/light_level_average_change_reporter.sv
module testbench;
  import llacr_pkg::*;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         SETTLE       = 40;
  localparam int         CYCLE_LIMIT  = 1000000;
  localparam int         HOLD_AT      = 600;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         PHASE_ITEMS  = 250;
  localparam int         MAX_PRINTED  = 30;

  typedef struct packed {
    logic [7:0] level;
    logic [7:0] mean;
    logic       last;
  } level_report_t;

  // tracks window, flags and threshold, and holds the reports still owed
  class level_report_predictor;
    logic [7:0]    window [WINDOW_DEFAULT];
    int            slot;
    int            fill;
    int            last_reported;
    bit            force_armed;
    int            threshold;
    int            mismatches;
    level_report_t owed_reports[$];

    function new();
      slot          = 0;
      fill          = 0;
      last_reported = 0;
      force_armed   = 0;
      threshold     = THRESHOLD_RESET;
      mismatches    = 0;
    endfunction

    function int pending();
      return owed_reports.size();
    endfunction

    function logic [7:0] brightness(input logic [15:0] raw);
      if (raw <= 3) return LEVEL_LOW;
      if (raw == 4) return LEVEL_FOUR;
      if (raw <= 16) return 8'(int'(LEVEL_BASE) + 10 * (int'(raw) - 5));
      return LEVEL_HIGH;
    endfunction

    function void accept_item(input logic [1:0] op, input logic [15:0] raw);
      logic [7:0]    lvl;
      int            sum;
      int            mean;
      int            diff;
      level_report_t rep;
      case (op)
        OP_ENABLE:  force_armed = 1;
        OP_DISABLE: force_armed = 0;
        OP_SAMPLE: begin
          lvl = brightness(raw);
          window[slot] = lvl;
          slot = (slot + 1 >= WINDOW_DEFAULT) ? 0 : slot + 1;
          if (fill < WINDOW_DEFAULT) fill++;
          sum = 0;
          for (int k = 0; k < fill; k++) sum += window[k];
          mean = sum / fill;
          diff = (mean >= last_reported) ? mean - last_reported : last_reported - mean;
          rep.level = lvl;
          rep.mean  = 8'(mean);
          if (diff >= threshold) begin
            rep.last = !force_armed;
            owed_reports.push_back(rep);
            last_reported = lvl;
          end
          if (force_armed) begin
            rep.last = 1'b1;
            owed_reports.push_back(rep);
            force_armed   = 0;
            last_reported = lvl;
          end
        end
        default: ;  // unused code, no effect
      endcase
    endfunction

    task report(input string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("ERROR: %0t ns: %s", $time, msg);
    endtask

    task check_report(input logic [7:0] level, input logic [7:0] mean, input logic last);
      level_report_t want;
      if (owed_reports.size() == 0) begin
        report($sformatf("unexpected report level %0d mean %0d last %0b", level, mean, last));
      end else begin
        want = owed_reports.pop_front();
        if (level !== want.level)
          report($sformatf("reported_level %0d, want %0d", level, want.level));
        if (mean !== want.mean)
          report($sformatf("window_mean %0d, want %0d", mean, want.mean));
        if (last !== want.last)
          report($sformatf("last_of_run %0b, want %0b", last, want.last));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;

  level_report_predictor levels = new();
  int accepted_items = 0;
  int cycles = 0;

  light_level_average_change_reporter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("light_level_average_change_reporter: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      levels.check_report(out_tdata[7:0], out_tdata[15:8], out_tlast);
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] rand_raw();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 16'($urandom_range(0, 20));
    if (r < 8) return 16'($urandom_range(0, 65535));
    return 16'($urandom_range(17, 40));
  endfunction

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_item(input logic [1:0] op, input logic [15:0] raw, input bit idle);
    int g;
    g = idle ? gap_len() : 0;
    if (g > 0) begin
      in_tvalid = 1'b0;
      repeat (g) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {6'b0, raw, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    levels.accept_item(op, raw);
    accepted_items++;
    @(negedge clk);
  endtask

  // no results owed, then room for a sample that reports nothing to finish
  task automatic wait_quiet();
    in_tvalid = 1'b0;
    while (levels.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_threshold(input logic [7:0] value);
    cfg_valid = 1'b1;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    levels.threshold = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic random_items(input int count);
    int         done;
    int         r;
    bit         idle;
    logic [1:0] op;
    done = 0;
    idle = 1'b1;
    while (done < count) begin
      if (done % 40 == 0) idle = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (r < 75) op = OP_SAMPLE;
      else if (r < 85) op = OP_ENABLE;
      else if (r < 93) op = OP_DISABLE;
      else op = OP_UNUSED;
      send_item(op, (op == OP_SAMPLE) ? rand_raw() : 16'($urandom_range(0, 65535)), idle);
      if (op != OP_UNUSED) done++;
    end
  endtask

  // result side: random stalls, free-running stretches, one long hold-off
  initial begin
    int  n;
    bit  held;
    held = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && accepted_items >= HOLD_AT) begin
        held = 1'b1;
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if ($urandom_range(0, 9) == 0) begin
        out_tready = 1'b1;
        repeat ($urandom_range(20, 80)) @(negedge clk);
      end else begin
        n = gap_len();
        if (n > 0) begin
          out_tready = 1'b0;
          repeat (n) @(negedge clk);
        end
        out_tready = 1'b1;
      end
    end
  end

  initial begin
    logic [7:0] thresholds [6];
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    thresholds = '{8'd0, 8'd255, 8'd15, 8'($urandom_range(1, 254)), 8'd150, 8'd60};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // mapping edges, both reports together, ignored code, re-arm and clear
    send_item(OP_SAMPLE, 16'd0, 1'b0);
    send_item(OP_SAMPLE, 16'd3, 1'b0);
    send_item(OP_SAMPLE, 16'd4, 1'b0);
    send_item(OP_SAMPLE, 16'd5, 1'b0);
    send_item(OP_SAMPLE, 16'd16, 1'b1);
    send_item(OP_SAMPLE, 16'd17, 1'b0);
    send_item(OP_SAMPLE, 16'hFFFF, 1'b0);
    send_item(OP_UNUSED, 16'hFFFF, 1'b0);
    send_item(OP_ENABLE, 16'h0000, 1'b0);
    send_item(OP_SAMPLE, 16'd0, 1'b0);
    send_item(OP_ENABLE, 16'h5555, 1'b1);
    send_item(OP_SAMPLE, 16'd1, 1'b0);
    send_item(OP_ENABLE, 16'h0000, 1'b0);
    send_item(OP_DISABLE, 16'hAAAA, 1'b0);
    send_item(OP_SAMPLE, 16'hAAAA, 1'b0);
    send_item(OP_SAMPLE, 16'h5555, 1'b1);
    send_item(OP_ENABLE, 16'h0000, 1'b0);
    send_item(OP_ENABLE, 16'h0000, 1'b0);
    send_item(OP_SAMPLE, 16'd4, 1'b0);
    send_item(OP_DISABLE, 16'h0000, 1'b0);
    send_item(OP_SAMPLE, 16'd2, 1'b0);
    send_item(OP_SAMPLE, 16'd10, 1'b0);
    send_item(OP_SAMPLE, 16'd16, 1'b0);
    wait_quiet();

    foreach (thresholds[p]) begin
      write_threshold(thresholds[p]);
      random_items(PHASE_ITEMS);
      wait_quiet();
    end

    if (levels.mismatches == 0 && levels.pending() == 0) begin
      $display("light_level_average_change_reporter: match");
    end else begin
      $display("light_level_average_change_reporter: mismatch");
    end
    $finish;
  end

endmodule
